FILE: hw/rtl/apsp_pkg.sv
// ----------------------------------------------------------------------------
// apsp_pkg: shared types and constants for the all-pairs shortest path unit
// Storage word widths, sequencer states and register codes.
// ----------------------------------------------------------------------------
package apsp_pkg;

    localparam int DIST_W   = 19;
    localparam int PRED_W   = 4;
    localparam int WEIGHT_W = 15;
    localparam int OUT_W    = 18;
    localparam int VC_W     = 4;

    localparam logic [WEIGHT_W-1:0] NO_EDGE   = 15'd23767;
    localparam logic [VC_W-1:0]     VC_RESET  = 4'd8;
    localparam logic [VC_W-1:0]     VC_MIN    = 4'd2;
    localparam logic                REG_VERTEX_COUNT = 1'b0;

    typedef logic [DIST_W-1:0]        dist_t;
    typedef logic signed [PRED_W-1:0] pred_t;

    localparam pred_t PRED_NONE = 4'sb1111;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_HEAD,
        ST_SWEEP,
        ST_OUT_READ,
        ST_OUT_WAIT
    } apsp_state_t;

endpackage

FILE: hw/rtl/apsp_store.sv
// ----------------------------------------------------------------------------
// apsp_store: distance and predecessor matrix storage
// One write port, two registered read ports for distance, one for predecessor.
// ----------------------------------------------------------------------------
module apsp_store #(
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  apsp_pkg::dist_t   wr_dist,
    input  apsp_pkg::pred_t   wr_pred,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output apsp_pkg::dist_t   rd_dist_a,
    output apsp_pkg::dist_t   rd_dist_b,
    output apsp_pkg::pred_t   rd_pred_b
);
    import apsp_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    dist_t dist_mem [DEPTH];
    pred_t pred_mem [DEPTH];

    dist_t rd_dist_a_reg;
    dist_t rd_dist_b_reg;
    pred_t rd_pred_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            dist_mem[wr_addr] <= wr_dist;
            pred_mem[wr_addr] <= wr_pred;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_dist_a_reg <= dist_mem[rd_addr_a];
            rd_dist_b_reg <= dist_mem[rd_addr_b];
            rd_pred_b_reg <= pred_mem[rd_addr_b];
        end
    end

    assign rd_dist_a = rd_dist_a_reg;
    assign rd_dist_b = rd_dist_b_reg;
    assign rd_pred_b = rd_pred_b_reg;

endmodule

FILE: hw/rtl/all_pairs_shortest_path_unit.sv
// ----------------------------------------------------------------------------
// all_pairs_shortest_path_unit: Floyd-Warshall over a loaded weight matrix
//
//   channel   dir   handshake          payload
//   s_        in    s_valid/s_ready    s_edge_weight
//   m_        out   m_valid/m_ready    m_distance, m_predecessor, m_last
//   apb       in    psel/penable       vertex_count at byte address 0
//
// Load: n*n words, each written as it is accepted. Relaxation uses one
// shared adder and comparator (a row-head read, then one step per cycle).
// Output: each word is read through the registered read port, then held
// until taken. Synchronous reset clears control and loads vertex_count = 8;
// the matrix storage has no clearing pass. A low m_ready holds the current
// word; s_ready is high only while loading.
// ----------------------------------------------------------------------------
module all_pairs_shortest_path_unit #(
    parameter int MAX_VERTICES = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [apsp_pkg::WEIGHT_W-1:0]  s_edge_weight,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [apsp_pkg::OUT_W-1:0]     m_distance,
    output apsp_pkg::pred_t                m_predecessor,
    output logic                           m_last
);
    import apsp_pkg::*;

    localparam int IDX_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int ADDR_W = 2 * IDX_W;
    localparam logic [VC_W-1:0] VC_MAX = VC_W'(MAX_VERTICES);

    apsp_state_t state_reg, state_next;

    logic [VC_W-1:0]   vc_reg;
    logic [VC_W-1:0]   n_act;
    logic [VC_W-1:0]   n_m1;
    logic [IDX_W-1:0]  via_reg, via_next;
    logic [IDX_W-1:0]  row_reg, row_next;
    logic [IDX_W-1:0]  col_reg, col_next;
    logic              last_col, last_row, last_via;

    logic              cfg_wr;
    logic              s_fire, m_fire;

    logic              rd_en;
    logic              sel_via_a;
    logic              sel_via_b;
    logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
    dist_t             rd_dist_a, rd_dist_b;
    pred_t             rd_pred_b;

    logic              cmp_vld_reg;
    logic              head_vld_reg;
    logic [ADDR_W-1:0] cmp_addr_reg;
    dist_t             dfv_reg;
    logic              out_last_reg;
    logic [DIST_W:0]   sum;
    logic              relax_wr;
    pred_t             load_pred;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    dist_t             wr_dist;
    pred_t             wr_pred;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_VERTEX_COUNT);
    assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? 32'(vc_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= VC_RESET;
        end else if (cfg_wr) begin
            vc_reg <= pwdata[VC_W-1:0];
        end
    end

    always_comb begin
        if (vc_reg < VC_MIN) begin
            n_act = VC_MIN;
        end else if (vc_reg > VC_MAX) begin
            n_act = VC_MAX;
        end else begin
            n_act = vc_reg;
        end
    end

    assign n_m1     = n_act - 4'd1;
    assign last_col = (VC_W'(col_reg) == n_m1);
    assign last_row = (VC_W'(row_reg) == n_m1);
    assign last_via = (VC_W'(via_reg) == n_m1);

    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_fire && last_row && last_col) state_next = ST_HEAD;
            end
            ST_HEAD: begin
                state_next = ST_SWEEP;
            end
            ST_SWEEP: begin
                if (last_col) begin
                    if (last_row && last_via) state_next = ST_OUT_READ;
                    else state_next = ST_HEAD;
                end
            end
            ST_OUT_READ: begin
                state_next = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                if (m_fire) state_next = out_last_reg ? ST_LOAD : ST_OUT_READ;
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // outputs
    always_comb begin
        s_ready   = 1'b0;
        m_valid   = 1'b0;
        rd_en     = 1'b0;
        sel_via_a = 1'b0;
        sel_via_b = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
            end
            ST_HEAD: begin
                rd_en     = 1'b1;
                sel_via_a = 1'b1;
            end
            ST_SWEEP: begin
                rd_en     = 1'b1;
                sel_via_b = 1'b1;
            end
            ST_OUT_READ: begin
                rd_en = 1'b1;
            end
            ST_OUT_WAIT: begin
                m_valid = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // counters
    always_comb begin
        via_next = via_reg;
        row_next = row_reg;
        col_next = col_reg;
        if ((state_reg == ST_LOAD && s_fire) || state_reg == ST_SWEEP ||
            (state_reg == ST_OUT_WAIT && m_fire)) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
        if (state_reg == ST_SWEEP && last_col && last_row) begin
            via_next = last_via ? '0 : via_reg + 1'b1;
        end
        if (cfg_wr) begin
            row_next = '0;
            col_next = '0;
            via_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            via_reg      <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            cmp_vld_reg  <= 1'b0;
            head_vld_reg <= 1'b0;
            out_last_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            via_reg      <= via_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            cmp_vld_reg  <= (state_reg == ST_SWEEP);
            head_vld_reg <= (state_reg == ST_HEAD);
            if (state_reg == ST_OUT_READ) out_last_reg <= last_row && last_col;
        end
    end

    assign rd_addr_a = {row_reg, (sel_via_a ? via_reg : col_reg)};
    assign rd_addr_b = {(sel_via_b ? via_reg : row_reg), col_reg};

    // hold the row's leg to the intermediate vertex, track the pending step
    always_ff @(posedge aclk) begin
        if (head_vld_reg) dfv_reg <= rd_dist_a;
        cmp_addr_reg <= {row_reg, col_reg};
    end

    assign sum      = {1'b0, dfv_reg} + {1'b0, rd_dist_b};
    assign relax_wr = cmp_vld_reg && (sum < {1'b0, rd_dist_a});

    assign load_pred = (s_edge_weight != '0 && s_edge_weight != NO_EDGE)
                     ? PRED_W'(row_reg) : PRED_NONE;

    assign wr_en   = relax_wr || s_fire;
    assign wr_addr = relax_wr ? cmp_addr_reg : {row_reg, col_reg};
    assign wr_dist = relax_wr ? sum[DIST_W-1:0] : DIST_W'(s_edge_weight);
    assign wr_pred = relax_wr ? rd_pred_b : load_pred;

    apsp_store #(
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_dist   (wr_dist),
        .wr_pred   (wr_pred),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_dist_a (rd_dist_a),
        .rd_dist_b (rd_dist_b),
        .rd_pred_b (rd_pred_b)
    );

    assign m_distance    = rd_dist_a[OUT_W-1:0];
    assign m_predecessor = rd_pred_b;
    assign m_last        = out_last_reg;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and output sides active together");

    a_load_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && last_row && last_col) |=> !s_ready)
        else $error("still taking words after the last weight");

    a_reopen: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && m_last) |=> s_ready)
        else $error("not reopened after the last result word");

    a_pred_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_predecessor == PRED_NONE ||
                     (!m_predecessor[PRED_W-1] && VC_W'(m_predecessor) < n_act)))
        else $error("predecessor outside the active vertex range");

endmodule

FILE: tb/tb_all_pairs_shortest_path_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_all_pairs_shortest_path_unit: self-checking bench for the APSP unit
// Loads weight matrices word by word, predicts distance/predecessor pairs
// with an in-bench Floyd-Warshall (typed directed rows give their own) and
// checks the output words in order. A short directed table covers reset
// value, a clamped vertex count, field extremes and a restart mid-load; random
// matrices of varied size follow, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_all_pairs_shortest_path_unit;
    import apsp_pkg::*;

    localparam int          MAX_V           = 8;
    localparam int          CELLS           = MAX_V * MAX_V;
    localparam int          TARGET_WORDS    = 460;
    localparam int          SETTLE_CYCLES   = 10;
    localparam int          TAIL_CYCLES     = 20;
    localparam int          HOLD_OFF_CYCLES = 400;
    localparam int          STALL_LIMIT     = 4000;
    localparam int          MAX_SHOWN       = 10;
    localparam logic [2:0]  VC_ADDR         = {REG_VERTEX_COUNT, 2'b00};

    typedef struct packed {
        logic [OUT_W-1:0] distance;
        pred_t            pred;
        logic             last;
    } pair_result_t;

    typedef enum logic [1:0] {
        ROW_CFG_WRITE,
        ROW_CFG_READ,
        ROW_WORD
    } row_kind_t;

    typedef struct packed {
        row_kind_t    kind;
        logic [31:0]  data;
        logic         typed;
        pair_result_t result;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [2:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 s_valid;
    logic                 s_ready;
    logic [WEIGHT_W-1:0]  s_edge_weight;
    logic                 m_valid;
    logic                 m_ready;
    logic [OUT_W-1:0]     m_distance;
    pred_t                m_predecessor;
    logic                 m_last;

    dist_t            dist_mem [CELLS];
    pred_t            pred_mem [CELLS];
    int unsigned      fill_cnt;
    logic [VC_W-1:0]  vc_reg;

    pair_result_t     expected_pairs [$];
    stim_row_t        directed_rows [$];
    int unsigned      mismatch_count;
    int unsigned      results_seen;
    int unsigned      words_sent;
    int unsigned      idle_cycles;
    pair_result_t     want;
    logic [VC_W-1:0]  opening_counts [5] = '{4'd2, 4'd8, 4'd15, 4'd1, 4'd9};

    all_pairs_shortest_path_unit #(
        .MAX_VERTICES (MAX_V)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_edge_weight (s_edge_weight),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_distance    (m_distance),
        .m_predecessor (m_predecessor),
        .m_last        (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic void flag_error(input string what, input longint exp_v,
                                       input longint got_v);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
            $display("mismatch on %s: expected %0d, got %0d", what, exp_v, got_v);
    endfunction

    function automatic int unsigned span_of(input logic [VC_W-1:0] v);
        if (v < VC_MIN) return VC_MIN;
        if (v > MAX_V) return MAX_V;
        return v;
    endfunction

    function automatic void relax_matrix(input int unsigned n);
        logic [DIST_W:0] via_sum;
        for (int unsigned via = 0; via < n; via++) begin
            for (int unsigned from = 0; from < n; from++) begin
                for (int unsigned to = 0; to < n; to++) begin
                    via_sum = {1'b0, dist_mem[from * n + via]} + {1'b0, dist_mem[via * n + to]};
                    if (via_sum < {1'b0, dist_mem[from * n + to]}) begin
                        dist_mem[from * n + to] = via_sum[DIST_W-1:0];
                        pred_mem[from * n + to] = pred_mem[via * n + to];
                    end
                end
            end
        end
    endfunction

    function automatic void absorb_weight(input logic [WEIGHT_W-1:0] w, input bit predicted);
        int unsigned n;
        int unsigned total;
        int unsigned pos;
        pair_result_t r;
        n = span_of(vc_reg);
        total = n * n;
        if (fill_cnt >= total) fill_cnt = 0;
        pos = fill_cnt;
        dist_mem[pos] = dist_t'(w);
        pred_mem[pos] = (w != 0 && w != NO_EDGE) ? pred_t'(pos / n) : PRED_NONE;
        fill_cnt = pos + 1;
        if (fill_cnt < total) return;
        fill_cnt = 0;
        relax_matrix(n);
        if (!predicted) return;
        for (int unsigned k = 0; k < total; k++) begin
            r.distance = dist_mem[k][OUT_W-1:0];
            r.pred     = pred_mem[k];
            r.last     = (k + 1 == total);
            expected_pairs.push_back(r);
        end
    endfunction

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight(input int unsigned row,
                                                        input int unsigned col);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (row == col) return (r < 90) ? '0 : WEIGHT_W'($urandom_range(0, 32767));
        if (r < 25) return NO_EDGE;
        if (r < 30) return '0;
        if (r < 80) return WEIGHT_W'($urandom_range(1, 60));
        if (r < 92) return WEIGHT_W'($urandom_range(1, 32767));
        return WEIGHT_W'($urandom_range(23768, 32767));
    endfunction

    function automatic void add_row(input row_kind_t kind, input int unsigned data,
                                    input logic typed, input int unsigned distance,
                                    input pred_t pred, input logic last);
        stim_row_t row;
        row.kind            = kind;
        row.data            = data;
        row.typed           = typed;
        row.result.distance = OUT_W'(distance);
        row.result.pred     = pred;
        row.result.last     = last;
        directed_rows.push_back(row);
    endfunction

    task automatic config_write(input logic [31:0] wdata);
        s_valid <= 1'b0;
        while (expected_pairs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= VC_ADDR;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        vc_reg   = wdata[VC_W-1:0];
        fill_cnt = 0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic config_check(input logic [VC_W-1:0] exp_vc);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= VC_ADDR;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== {{(32-VC_W){1'b0}}, exp_vc})
            flag_error("vertex_count readback", exp_vc, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic push_weight(input logic [WEIGHT_W-1:0] w, input bit typed,
                               input pair_result_t typed_res, input bit no_gaps);
        int unsigned gap;
        gap = no_gaps ? 0 : idle_len();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_edge_weight <= w;
        do @(posedge aclk); while (!s_ready);
        if (typed) expected_pairs.push_back(typed_res);
        absorb_weight(w, !typed);
        words_sent++;
    endtask

    // check every result word against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_pairs.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN)
                    $display("unexpected word: distance %0d predecessor %0d last %0d",
                             m_distance, m_predecessor, m_last);
            end else begin
                want = expected_pairs.pop_front();
                if (m_distance !== want.distance)
                    flag_error("distance", want.distance, m_distance);
                if (m_predecessor !== want.pred)
                    flag_error("predecessor", want.pred, m_predecessor);
                if (m_last !== want.last)
                    flag_error("last", want.last, m_last);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_all_pairs_shortest_path_unit: done, errors");
            $finish;
        end
    end

    initial begin : result_sink
        int unsigned on_len;
        int unsigned off_len;
        bit          held;
        held = 1'b0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            // hold off once while the sender is blocked behind a full block
            if (!held && results_seen >= 64 && m_valid && s_valid) begin
                held    = 1'b1;
                off_len = HOLD_OFF_CYCLES;
            end else begin
                off_len = idle_len();
            end
            if (off_len != 0) begin
                m_ready <= 1'b0;
                repeat (off_len) @(posedge aclk);
            end
            on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 8);
            m_ready <= 1'b1;
            repeat (on_len) @(posedge aclk);
        end
    end

    initial begin : stimulus
        stim_row_t       row;
        logic [VC_W-1:0] vc;
        int unsigned     n;
        int unsigned     mats;
        int unsigned     phase;
        bit              quiet;

        mismatch_count = 0;
        results_seen   = 0;
        words_sent     = 0;
        idle_cycles    = 0;
        fill_cnt       = 0;
        vc_reg         = VC_RESET;
        aresetn       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_valid       <= 1'b0;
        s_edge_weight <= '0;

        add_row(ROW_CFG_READ,  32'(VC_RESET), 1'b1, 0, PRED_NONE, 1'b0);
        add_row(ROW_CFG_WRITE, 32'd0,     1'b0, 0, PRED_NONE, 1'b0);
        add_row(ROW_CFG_READ,  32'd0,     1'b1, 0, PRED_NONE, 1'b0);
        add_row(ROW_WORD,      32'd0,     1'b1, 0, PRED_NONE, 1'b0);
        add_row(ROW_WORD,      32'd32767, 1'b1, 32767, 4'sd0, 1'b0);
        add_row(ROW_WORD,      32'(NO_EDGE), 1'b1, 32'(NO_EDGE), PRED_NONE, 1'b0);
        add_row(ROW_WORD,      32'd0,     1'b1, 0, PRED_NONE, 1'b1);
        add_row(ROW_WORD,      32'd0,     1'b1, 0, PRED_NONE, 1'b0);
        add_row(ROW_WORD,      32'd16384, 1'b1, 16384, 4'sd0, 1'b0);
        add_row(ROW_WORD,      32'd1,     1'b1, 1, 4'sd1, 1'b0);
        add_row(ROW_WORD,      32'd0,     1'b1, 0, PRED_NONE, 1'b1);
        add_row(ROW_WORD,      32'd16384, 1'b0, 0, PRED_NONE, 1'b0);
        add_row(ROW_WORD,      32'd1,     1'b0, 0, PRED_NONE, 1'b0);
        add_row(ROW_WORD,      32'd10922, 1'b0, 0, PRED_NONE, 1'b0);
        add_row(ROW_WORD,      32'd21845, 1'b0, 0, PRED_NONE, 1'b0);
        add_row(ROW_CFG_WRITE, 32'd3,     1'b0, 0, PRED_NONE, 1'b0);
        add_row(ROW_WORD,      32'd9,     1'b0, 0, PRED_NONE, 1'b0);
        add_row(ROW_WORD,      32'(NO_EDGE), 1'b0, 0, PRED_NONE, 1'b0);
        add_row(ROW_WORD,      32'd300,   1'b0, 0, PRED_NONE, 1'b0);
        add_row(ROW_WORD,      32'd12,    1'b0, 0, PRED_NONE, 1'b0);
        add_row(ROW_CFG_WRITE, 32'hFFFF_FFF3, 1'b0, 0, PRED_NONE, 1'b0);
        add_row(ROW_CFG_READ,  32'd3,     1'b1, 0, PRED_NONE, 1'b0);
        add_row(ROW_WORD,      32'd0,     1'b0, 0, PRED_NONE, 1'b0);
        add_row(ROW_WORD,      32'd0,     1'b0, 0, PRED_NONE, 1'b0);
        add_row(ROW_WORD,      32'd7,     1'b0, 0, PRED_NONE, 1'b0);
        add_row(ROW_WORD,      32'd4,     1'b0, 0, PRED_NONE, 1'b0);
        add_row(ROW_WORD,      32'd0,     1'b0, 0, PRED_NONE, 1'b0);
        add_row(ROW_WORD,      32'(NO_EDGE), 1'b0, 0, PRED_NONE, 1'b0);
        add_row(ROW_WORD,      32'd5,     1'b0, 0, PRED_NONE, 1'b0);
        add_row(ROW_WORD,      32'(NO_EDGE), 1'b0, 0, PRED_NONE, 1'b0);
        add_row(ROW_WORD,      32'd0,     1'b0, 0, PRED_NONE, 1'b0);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < directed_rows.size(); i++) begin
            row = directed_rows[i];
            case (row.kind)
                ROW_CFG_WRITE: config_write(row.data);
                ROW_CFG_READ:  config_check(row.data[VC_W-1:0]);
                default:       push_weight(row.data[WEIGHT_W-1:0], row.typed, row.result, 1'b0);
            endcase
        end

        phase = 0;
        while (words_sent < TARGET_WORDS) begin
            if (phase < 5)
                vc = opening_counts[phase];
            else if ($urandom_range(0, 3) == 0)
                vc = VC_W'($urandom_range(0, 15));
            else
                vc = VC_W'($urandom_range(2, 5));
            config_write({28'($urandom_range(0, 32'h0FFF_FFFF)), vc});
            config_check(vc_reg);
            n     = span_of(vc_reg);
            quiet = ($urandom_range(0, 3) == 0);
            // broken load: drop it by rewriting the count
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, n * n - 1))
                    push_weight(pick_weight(0, 1), 1'b0, '0, quiet);
                config_write({28'd0, vc_reg});
            end
            mats = (phase < 5) ? 2 : $urandom_range(1, 3);
            repeat (mats) begin
                if (words_sent < TARGET_WORDS) begin
                    for (int unsigned r = 0; r < n; r++)
                        for (int unsigned c = 0; c < n; c++)
                            push_weight(pick_weight(r, c), 1'b0, '0, quiet);
                end
            end
            phase++;
        end

        s_valid <= 1'b0;
        while (expected_pairs.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("tb_all_pairs_shortest_path_unit: done, clean");
        else
            $display("tb_all_pairs_shortest_path_unit: done, errors");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/apsp_pkg.sv
hw/rtl/apsp_store.sv
hw/rtl/all_pairs_shortest_path_unit.sv
tb/tb_all_pairs_shortest_path_unit.sv
